FILE: sv/vfsg_pkg.sv
// Shared types, widths, register codes and Q24 helpers for the soft noise gate.
package vfsg_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 25;
  localparam int FRAME_LEN_W = 12;
  localparam int THRESH_W    = 31;
  localparam int SQ_W        = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int Q24_FRAC    = 24;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [GAIN_W-1:0]     gain_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam gain_t   Q24_ONE    = 25'h100_0000;
  localparam sample_t SAMPLE_MAX = 16'h7FFF;
  localparam sample_t SAMPLE_MIN = 16'h8000;

  localparam cfg_idx_t CFG_FRAME_LEN     = 3'd0;
  localparam cfg_idx_t CFG_MS_THRESHOLD  = 3'd1;
  localparam cfg_idx_t CFG_FLOOR_GAIN    = 3'd2;
  localparam cfg_idx_t CFG_ATTACK_COEF   = 3'd3;
  localparam cfg_idx_t CFG_RELEASE_COEF  = 3'd4;

  // Clamp a Q24 gain to one.
  function automatic gain_t sat_q24(input gain_t v);
    return (v > Q24_ONE) ? Q24_ONE : v;
  endfunction

endpackage

FILE: sv/vfsg_in_if.sv
// Input sample channel: valid/ready plus sample and external voice flag.
interface vfsg_in_if;
  logic              valid;
  logic              ready;
  vfsg_pkg::sample_t in_sample;
  logic              ext_speech;

  modport source (output valid, output in_sample, output ext_speech, input ready);
  modport sink   (input valid, input in_sample, input ext_speech, output ready);
endinterface

FILE: sv/vfsg_out_if.sv
// Result channel: valid/ready plus gated sample, applied gain and frame decision.
interface vfsg_out_if;
  logic              valid;
  logic              ready;
  vfsg_pkg::sample_t out_sample;
  vfsg_pkg::gain_t   gain_now;
  logic              frame_is_speech;

  modport source (output valid, output out_sample, output gain_now,
                  output frame_is_speech, input ready);
  modport sink   (input valid, input out_sample, input gain_now,
                  input frame_is_speech, output ready);
endinterface

FILE: sv/vfsg_cfg_if.sv
// Configuration write channel: valid/ready plus register index and data.
interface vfsg_cfg_if;
  logic                valid;
  logic                ready;
  vfsg_pkg::cfg_idx_t  index;
  vfsg_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/vfsg_frame_store.sv
// Ping-pong frame store: one write port, one registered read port.
module vfsg_frame_store #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  vfsg_pkg::sample_t        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output vfsg_pkg::sample_t        rd_data
);

  vfsg_pkg::sample_t mem [DEPTH];
  vfsg_pkg::sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/vad_frame_soft_gate_top.sv
// Frame-gated soft noise gate: frame store, energy decision and one-pole gain.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  in_ch   | in  | valid & ready        | in_sample s16, ext_speech u1
//  out_ch  | out | valid & ready        | out_sample s16, gain_now u25 Q24,
//          |     |                      | frame_is_speech u1
//  cfg_ch  | in  | valid & ready        | index u3, data u31 (ready always high)
//
// Each item passes through four steps: accept (frame store read issued, gain
// product and sample square formed), gain update, output multiply with energy
// add and threshold product, then write-back and result load. The sequencer
// takes a new item only after the current one has left the write-back step.
// Reset (rst_n low, synchronous) clears control state and reloads the register
// defaults; the frame store is not cleared. A result waiting in the output
// register does not block the next item; only the write-back step stalls when
// that register is still full.
module vad_frame_soft_gate_top #(
  parameter int MAX_FRAME = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  vfsg_in_if.sink    in_ch,
  vfsg_out_if.source out_ch,
  vfsg_cfg_if.sink   cfg_ch
);

  localparam int POS_W      = $clog2(MAX_FRAME);
  localparam int LEN_W      = $clog2(MAX_FRAME + 1);
  localparam int DEPTH      = 2 * MAX_FRAME;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ENERGY_W   = vfsg_pkg::SQ_W + POS_W;
  localparam int THRLEN_W   = vfsg_pkg::THRESH_W + LEN_W;
  localparam int CMP_W      = (ENERGY_W > THRLEN_W) ? ENERGY_W : THRLEN_W;
  localparam int GPROD_W    = 2 * vfsg_pkg::GAIN_W;
  localparam int GR_W       = GPROD_W + 1 - vfsg_pkg::Q24_FRAC;
  localparam int MPROD_W    = vfsg_pkg::SAMPLE_W + vfsg_pkg::GAIN_W;
  localparam int MR_W       = MPROD_W + 1 - vfsg_pkg::Q24_FRAC;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GAIN = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // Registers
  logic [1:0] state_r, state_nxt;

  logic [vfsg_pkg::FRAME_LEN_W-1:0] frame_len_r;
  logic [vfsg_pkg::THRESH_W-1:0]    thresh_r;
  vfsg_pkg::gain_t                  floor_r, attack_r, release_r;

  logic [POS_W-1:0]    pos_r;
  logic                bank_r;
  logic [ENERGY_W-1:0] energy_r;
  vfsg_pkg::gain_t     gate_gain_r, target_r, coef_r;
  logic                speech_r, primed_r;

  vfsg_pkg::sample_t             sample_r;
  logic                          ext_r;
  logic [LEN_W-1:0]              len_r;
  logic [vfsg_pkg::SQ_W-1:0]     sq_r;
  logic [GPROD_W-1:0]            gprod_r;
  logic                          up_r;
  vfsg_pkg::gain_t               gn_r;
  logic [MPROD_W-1:0]            mprod_r;
  logic                          neg_r;
  logic [ENERGY_W-1:0]           energy_new_r;
  logic [THRLEN_W-1:0]           thrlen_r;

  logic              out_valid_r;
  vfsg_pkg::sample_t out_sample_r;
  vfsg_pkg::gain_t   out_gain_r;
  logic              out_speech_r;

  // Combinational
  logic                          in_acc, out_load;
  logic [LEN_W-1:0]              len_c;
  logic [ADDR_W-1:0]             rd_addr, wr_addr;
  vfsg_pkg::sample_t             old_data;
  logic                          up_c;
  vfsg_pkg::gain_t               diff_c;
  logic [GPROD_W-1:0]            gprod_c;
  logic signed [2*vfsg_pkg::SAMPLE_W-1:0] sq_full;
  logic [GPROD_W:0]              gsum;
  logic [GR_W-1:0]               grnd, gadd;
  vfsg_pkg::gain_t               gn_c;
  vfsg_pkg::sample_t             old_abs;
  logic [MPROD_W-1:0]            mprod_c;
  logic [MPROD_W:0]              msum;
  logic [MR_W-1:0]               mag, mag_neg;
  vfsg_pkg::sample_t             y_c;
  logic                          frame_end_c, speech_c;
  vfsg_pkg::gain_t               target_c, coef_c;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // Effective frame length: zero acts as one, anything above MAX_FRAME as MAX_FRAME.
  always_comb begin
    if (frame_len_r == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(frame_len_r) > 32'(MAX_FRAME)) begin
      len_c = LEN_W'(MAX_FRAME);
    end else begin
      len_c = LEN_W'(frame_len_r);
    end
  end

  // Read the previous frame's bank, write the filling bank, same position.
  assign rd_addr = bank_r ? ADDR_W'(pos_r) : ADDR_W'(MAX_FRAME) + ADDR_W'(pos_r);
  assign wr_addr = bank_r ? ADDR_W'(MAX_FRAME) + ADDR_W'(pos_r) : ADDR_W'(pos_r);

  vfsg_frame_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (out_load),
    .wr_addr (wr_addr),
    .wr_data (sample_r),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (old_data)
  );

  // Accept step: gain step product and sample square.
  always_comb begin
    up_c    = (target_r >= gate_gain_r);
    diff_c  = up_c ? (target_r - gate_gain_r) : (gate_gain_r - target_r);
    gprod_c = GPROD_W'(diff_c) * GPROD_W'(coef_r);
    sq_full = $signed(in_ch.in_sample) * $signed(in_ch.in_sample);
  end

  // Gain step: round the product, move toward target, clamp to [0, one]; hold until primed.
  always_comb begin
    gsum = {1'b0, gprod_r} + ((GPROD_W + 1)'(1) << (vfsg_pkg::Q24_FRAC - 1));
    grnd = gsum[GPROD_W:vfsg_pkg::Q24_FRAC];
    gadd = GR_W'(gate_gain_r) + grnd;
    if (!primed_r) begin
      gn_c = gate_gain_r;
    end else if (up_r) begin
      gn_c = (gadd > GR_W'(vfsg_pkg::Q24_ONE)) ? vfsg_pkg::Q24_ONE
                                                : vfsg_pkg::GAIN_W'(gadd);
    end else begin
      gn_c = (grnd >= GR_W'(gate_gain_r)) ? '0
                                          : gate_gain_r - vfsg_pkg::GAIN_W'(grnd);
    end
  end

  // Multiply step: scale the stored sample magnitude.
  always_comb begin
    old_abs = old_data[vfsg_pkg::SAMPLE_W-1] ? (~old_data + 1'b1) : old_data;
    mprod_c = MPROD_W'(old_abs) * MPROD_W'(gn_r);
  end

  // Write-back step: round and saturate the output (zero until primed), decide at frame end.
  always_comb begin
    msum    = {1'b0, mprod_r} + ((MPROD_W + 1)'(1) << (vfsg_pkg::Q24_FRAC - 1));
    mag     = msum[MPROD_W:vfsg_pkg::Q24_FRAC];
    mag_neg = ~mag + 1'b1;
    if (!primed_r) begin
      y_c = '0;
    end else if (neg_r) begin
      y_c = (mag > MR_W'(vfsg_pkg::SAMPLE_MIN)) ? vfsg_pkg::SAMPLE_MIN
                                                : vfsg_pkg::SAMPLE_W'(mag_neg);
    end else begin
      y_c = (mag > MR_W'(vfsg_pkg::SAMPLE_MAX)) ? vfsg_pkg::SAMPLE_MAX
                                                : vfsg_pkg::SAMPLE_W'(mag);
    end
    frame_end_c = (LEN_W'(pos_r) + LEN_W'(1)) >= len_r;
    speech_c    = ext_r || (CMP_W'(energy_new_r) > CMP_W'(thrlen_r));
    target_c    = speech_c ? vfsg_pkg::Q24_ONE : vfsg_pkg::sat_q24(floor_r);
    coef_c      = (target_c > gn_r) ? vfsg_pkg::sat_q24(attack_r)
                                    : vfsg_pkg::sat_q24(release_r);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_len_r <= 12'd960;
      thresh_r    <= 31'd107374;
      floor_r     <= 25'd1677722;
      attack_r    <= 25'd173862;
      release_r   <= 25'd4368;
      pos_r       <= '0;
      bank_r      <= 1'b0;
      energy_r    <= '0;
      gate_gain_r <= vfsg_pkg::Q24_ONE;
      target_r    <= vfsg_pkg::Q24_ONE;
      coef_r      <= '0;
      speech_r    <= 1'b0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          vfsg_pkg::CFG_FRAME_LEN:
            frame_len_r <= cfg_ch.data[vfsg_pkg::FRAME_LEN_W-1:0];
          vfsg_pkg::CFG_MS_THRESHOLD:
            thresh_r    <= cfg_ch.data[vfsg_pkg::THRESH_W-1:0];
          vfsg_pkg::CFG_FLOOR_GAIN:
            floor_r     <= cfg_ch.data[vfsg_pkg::GAIN_W-1:0];
          vfsg_pkg::CFG_ATTACK_COEF:
            attack_r    <= cfg_ch.data[vfsg_pkg::GAIN_W-1:0];
          vfsg_pkg::CFG_RELEASE_COEF:
            release_r   <= cfg_ch.data[vfsg_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        gate_gain_r <= gn_r;
        if (frame_end_c) begin
          // Close the frame: latch decision, swap banks, restart the count.
          target_r <= target_c;
          coef_r   <= coef_c;
          speech_r <= speech_c;
          primed_r <= 1'b1;
          bank_r   <= ~bank_r;
          pos_r    <= '0;
          energy_r <= '0;
        end else begin
          pos_r    <= pos_r + 1'b1;
          energy_r <= energy_new_r;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_ch.in_sample;
      ext_r    <= in_ch.ext_speech;
      len_r    <= len_c;
      sq_r     <= vfsg_pkg::SQ_W'(sq_full);
      gprod_r  <= gprod_c;
      up_r     <= up_c;
    end
    if (state_r == ST_GAIN) begin
      gn_r <= gn_c;
    end
    if (state_r == ST_MUL) begin
      mprod_r      <= mprod_c;
      neg_r        <= old_data[vfsg_pkg::SAMPLE_W-1];
      energy_new_r <= energy_r + ENERGY_W'(sq_r);
      thrlen_r     <= THRLEN_W'(thresh_r) * THRLEN_W'(len_r);
    end
    if (out_load) begin
      out_sample_r <= y_c;
      out_gain_r   <= gn_r;
      out_speech_r <= primed_r && speech_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_sample      = out_sample_r;
  assign out_ch.gain_now        = out_gain_r;
  assign out_ch.frame_is_speech = out_speech_r;

`ifndef ASSERT_OFF
  a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##3 (state_r == ST_OUT))
    else $error("item did not reach write-back three cycles after accept");

  a_bank_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> !bank_r)
    else $error("bank swapped before first frame closed");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gate_gain_r <= vfsg_pkg::Q24_ONE)
    else $error("gate gain above one");

  a_first_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !primed_r) |=> (out_sample_r == '0) && !out_speech_r)
    else $error("first frame result not silent");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < 32'(MAX_FRAME))
    else $error("write position past frame store");
`endif

endmodule
